// File: sv/butf_pkg.sv
package butf_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgByteLimit = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgReplace   = 8'd1;

  localparam logic [15:0] LimitReset = 16'd4096;

  localparam logic [7:0] Lead2Lo   = 8'hC2;
  localparam logic [7:0] Lead2Hi   = 8'hDF;
  localparam logic [7:0] Lead3Lo   = 8'hE0;
  localparam logic [7:0] Lead3Hi   = 8'hEF;
  localparam logic [7:0] Lead4Lo   = 8'hF0;
  localparam logic [7:0] Lead4Hi   = 8'hF4;
  localparam logic [7:0] LeadSurr  = 8'hED;
  localparam logic [7:0] Cont3Min  = 8'hA0;
  localparam logic [7:0] Cont4Min  = 8'h90;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContMark  = 8'h80;

  localparam logic [7:0] Repl0 = 8'hEF;
  localparam logic [7:0] Repl1 = 8'hBF;
  localparam logic [7:0] Repl2 = 8'hBD;

  typedef struct packed {
    logic load;
    logic step;
    logic push;
  } butf_cmd_t;

  typedef struct packed {
    logic step_emits;
    logic step_drains;
    logic emit_last;
    logic out_free;
    logic q_empty;
  } butf_stat_t;

  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] len;
    len = 3'd0;
    if (lead < ContMark) begin
      len = 3'd1;
    end else if (lead >= Lead2Lo && lead <= Lead2Hi) begin
      len = 3'd2;
    end else if (lead >= Lead3Lo && lead <= Lead3Hi) begin
      len = 3'd3;
    end else if (lead >= Lead4Lo && lead <= Lead4Hi) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

// File: sv/butf_ctrl.sv
module butf_ctrl
  import butf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output butf_cmd_t  cmd_o,
  input  butf_stat_t stat_i
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDecide = 2'd1;
  localparam logic [1:0] StEmit   = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecide;
        end
      end
      StDecide: begin
        cmd_o.step = 1'b1;
        if (stat_i.step_emits) begin
          state_d = StEmit;
        end else if (stat_i.step_drains) begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        cmd_o.push = stat_i.out_free;
        if (stat_i.out_free && stat_i.emit_last) begin
          state_d = stat_i.q_empty ? StIdle : StDecide;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/butf_dp.sv
module butf_dp
  import butf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  butf_cmd_t           cmd_i,
  output butf_stat_t          stat_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                is_end_o,
  output logic                utf8_ok_o
);

  typedef struct packed {
    logic [7:0] b;
    logic       e;
    logic       ok;
  } item_t;

  logic [15:0] limit_q;
  logic        replace_q;

  logic [7:0]  q_q [4];
  logic [2:0]  qcnt_q;
  logic [7:0]  pend_q [3];
  logic [1:0]  pc_q;
  logic [2:0]  el_q;
  logic [15:0] emitted_q;
  logic        stop_q, err_q;
  item_t       ebuf_q [4];
  logic [2:0]  ecnt_q;
  logic        out_valid_q;
  item_t       out_q;

  logic [7:0]  st_q [4];
  logic [2:0]  st_qcnt;
  logic [7:0]  st_pend [3];
  logic [1:0]  st_pc;
  logic [2:0]  st_el;
  logic [15:0] st_emitted;
  logic        st_stop, st_err;
  item_t       st_ebuf [4];
  logic [2:0]  st_ecnt;

  logic [7:0]  c, lead;
  logic [2:0]  len, addlen;
  logic        cont_ok, fits, at_limit;
  logic [16:0] sum;

  assign c        = q_q[0];
  assign lead     = pend_q[0];
  assign len      = seq_len(c);
  assign at_limit = emitted_q >= limit_q;

  always_comb begin
    cont_ok = (c & ContMask) == ContMark;
    if (cont_ok && pc_q == 2'd1) begin
      if (el_q == 3'd3) begin
        cont_ok = !(lead == Lead3Lo && c < Cont3Min) && !(lead == LeadSurr && c >= Cont3Min);
      end else if (el_q == 3'd4) begin
        cont_ok = !(lead == Lead4Lo && c < Cont4Min) && !(lead == Lead4Hi && c >= Cont4Min);
      end
    end
  end

  assign addlen = (el_q != 3'd0 && cont_ok) ? el_q : 3'd3;
  assign sum    = {1'b0, emitted_q} + {14'd0, addlen};
  assign fits   = sum <= {1'b0, limit_q};

  always_comb begin
    logic invalid;
    logic finish;
    invalid    = 1'b0;
    finish     = 1'b0;
    st_pend    = pend_q;
    st_pc      = pc_q;
    st_el      = el_q;
    st_emitted = emitted_q;
    st_stop    = stop_q;
    st_err     = err_q;
    for (int j = 0; j < 3; j++) begin
      st_q[j] = q_q[j+1];
    end
    st_q[3]  = q_q[3];
    st_qcnt  = qcnt_q - 3'd1;
    for (int j = 0; j < 4; j++) begin
      st_ebuf[j] = '{b: c, e: 1'b0, ok: 1'b0};
    end
    st_ecnt = 3'd0;

    if (stop_q || err_q) begin
      finish = (c == 8'd0);
    end else if (el_q == 3'd0) begin
      if (c == 8'd0) begin
        finish = 1'b1;
      end else if (at_limit) begin
        st_stop = 1'b1;
      end else if (len == 3'd0) begin
        invalid = 1'b1;
      end else if (len == 3'd1) begin
        st_ecnt    = 3'd1;
        st_emitted = emitted_q + 16'd1;
      end else begin
        st_pend[0] = c;
        st_pc      = 2'd1;
        st_el      = len;
      end
    end else if (!cont_ok) begin
      invalid = 1'b1;
      unique case (pc_q)
        2'd2: begin
          st_q[0] = pend_q[1];
          st_q[1] = q_q[0];
          st_q[2] = q_q[1];
          st_q[3] = q_q[2];
        end
        2'd3: begin
          st_q[0] = pend_q[1];
          st_q[1] = pend_q[2];
          st_q[2] = q_q[0];
          st_q[3] = q_q[1];
        end
        default: begin
          st_q[0] = q_q[0];
          st_q[1] = q_q[1];
          st_q[2] = q_q[2];
          st_q[3] = q_q[3];
        end
      endcase
      st_qcnt = qcnt_q + {1'b0, pc_q} - 3'd1;
    end else if ({1'b0, pc_q} + 3'd1 == el_q) begin
      if (fits) begin
        for (int j = 0; j < 3; j++) begin
          st_ebuf[j].b = pend_q[j];
        end
        st_ebuf[pc_q].b = c;
        st_ecnt         = {1'b0, pc_q} + 3'd1;
        st_emitted      = emitted_q + {13'd0, el_q};
      end else begin
        st_stop = 1'b1;
      end
      st_pc = 2'd0;
      st_el = 3'd0;
    end else begin
      if (pc_q != 2'd3) begin
        st_pend[pc_q] = c;
      end
      st_pc = pc_q + 2'd1;
    end

    if (invalid) begin
      st_pc = 2'd0;
      st_el = 3'd0;
      if (!replace_q) begin
        st_err = 1'b1;
      end else if (fits) begin
        st_ebuf[0].b = Repl0;
        st_ebuf[1].b = Repl1;
        st_ebuf[2].b = Repl2;
        st_ecnt      = 3'd3;
        st_emitted   = emitted_q + 16'd3;
      end else begin
        st_stop = 1'b1;
      end
    end

    if (finish) begin
      st_ebuf[0] = '{b: 8'd0, e: 1'b1, ok: !err_q};
      st_ecnt    = 3'd1;
      st_pc      = 2'd0;
      st_el      = 3'd0;
      st_emitted = 16'd0;
      st_stop    = 1'b0;
      st_err     = 1'b0;
    end
  end

  assign stat_o.step_emits  = st_ecnt != 3'd0;
  assign stat_o.step_drains = st_qcnt == 3'd0;
  assign stat_o.emit_last   = ecnt_q == 3'd1;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign stat_o.q_empty     = qcnt_q == 3'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      replace_q   <= 1'b0;
      qcnt_q      <= 3'd0;
      pc_q        <= 2'd0;
      el_q        <= 3'd0;
      emitted_q   <= 16'd0;
      stop_q      <= 1'b0;
      err_q       <= 1'b0;
      ecnt_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CfgByteLimit) begin
        limit_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CfgReplace) begin
        replace_q <= cfg_data_i[0];
      end
      if (cmd_i.load) begin
        qcnt_q <= (in_byte_i != 8'd0 && in_last_i) ? 3'd2 : 3'd1;
      end else if (cmd_i.step) begin
        qcnt_q    <= st_qcnt;
        pc_q      <= st_pc;
        el_q      <= st_el;
        emitted_q <= st_emitted;
        stop_q    <= st_stop;
        err_q     <= st_err;
        ecnt_q    <= st_ecnt;
      end else if (cmd_i.push) begin
        ecnt_q <= ecnt_q - 3'd1;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      q_q[0] <= in_byte_i;
      q_q[1] <= 8'd0;
    end else if (cmd_i.step) begin
      q_q     <= st_q;
      pend_q  <= st_pend;
      ebuf_q  <= st_ebuf;
    end else if (cmd_i.push) begin
      for (int j = 0; j < 3; j++) begin
        ebuf_q[j] <= ebuf_q[j+1];
      end
    end
    if (cmd_i.push) begin
      out_q <= ebuf_q[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_q.b;
  assign is_end_o    = out_q.e;
  assign utf8_ok_o   = out_q.ok;

`ifndef SYNTHESIS
  a_push_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> ecnt_q != 3'd0)
    else $error("Output beat pushed from an empty emit buffer.");

  a_step_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (qcnt_q != 3'd0 && ecnt_q == 3'd0))
    else $error("Decision taken without a byte or with results still waiting.");

  a_seq_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (el_q == 3'd0) == (pc_q == 2'd0))
    else $error("Sequence length and pending count disagree.");

  a_pend_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (el_q != 3'd0) |-> ({1'b0, pc_q} < el_q))
    else $error("Pending count has reached the sequence length.");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && ebuf_q[0].e) |=> (emitted_q == 16'd0 && !stop_q && !err_q))
    else $error("String state not cleared after the end beat.");
`endif

endmodule

// File: sv/bounded_utf8_sanitizer_top.sv
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    in_byte_i, in_last_i
// out       out_valid_o / out_ready_i  out_byte_o, is_end_o, utf8_ok_o
// cfg       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An input byte is first loaded, then goes through one decision per byte it puts
// through the decoder (replayed bytes included) and one push per output beat.
// Output stalls hold the emit stage; the final result register is a separate stage.
// Reset is asynchronous; no clearing pass follows it, and the pending bytes are not reset.
// Configuration writes are always taken and act on the next decision.
module bounded_utf8_sanitizer_top
  import butf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                is_end_o,
  output logic                utf8_ok_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  butf_cmd_t  cmd;
  butf_stat_t stat;

  assign cfg_ready_o = 1'b1;

  butf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  butf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .is_end_o    (is_end_o),
    .utf8_ok_o   (utf8_ok_o)
  );

endmodule
